FILE: rtl/assert_macros.svh
// Assertion macros shared by the RTL files that carry concurrent checks.
// Defining ASSERT_OFF removes every check and leaves the macros empty.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Checks expr at every rising clock edge while reset is released.
`define ASSERT_CLK(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) else $error(msg);
// Checks that cond implies expr at the same rising clock edge.
`define ASSERT_IMPL(lbl, clk, rst_n, cond, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (expr)) \
        else $error(msg);
// Checks that cond implies expr at the next rising clock edge.
`define ASSERT_NEXT(lbl, clk, rst_n, cond, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (expr)) \
        else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst_n, expr, msg)
`define ASSERT_IMPL(lbl, clk, rst_n, cond, expr, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, cond, expr, msg)
`endif
`endif

FILE: rtl/gvfe_pkg.sv
// Package of the GLL/VTG field extractor: character codes, fixed phase numbers,
// write target codes and the result structure. No dependencies.
`timescale 1ns / 1ps

package gvfe_pkg;

    // Characters the parser looks for.
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_G      = 8'h47;
    localparam logic [7:0] CH_L      = 8'h4C;
    localparam logic [7:0] CH_N      = 8'h4E;
    localparam logic [7:0] CH_P      = 8'h50;
    localparam logic [7:0] CH_T      = 8'h54;
    localparam logic [7:0] CH_V      = 8'h56;

    // Fixed phase numbers.
    localparam logic [7:0] PH_IDLE     = 8'd0;
    localparam logic [7:0] PH_HEAD_P   = 8'd1;
    localparam logic [7:0] PH_HEAD_G   = 8'd2;
    localparam logic [7:0] PH_HEAD_L1  = 8'd3;
    localparam logic [7:0] PH_HEAD_L2  = 8'd4;
    localparam logic [7:0] PH_HEAD_CM  = 8'd5;
    localparam logic [7:0] PH_LAT      = 8'd20;
    localparam logic [7:0] PH_NS       = 8'd40;
    localparam logic [7:0] PH_NS_SEEN  = 8'd41;
    localparam logic [7:0] PH_NS_END   = 8'd45;
    localparam logic [7:0] PH_LON      = 8'd50;
    localparam logic [7:0] PH_EW       = 8'd70;
    localparam logic [7:0] PH_EW_SEEN  = 8'd71;
    localparam logic [7:0] PH_TIME     = 8'd75;
    localparam logic [7:0] PH_TIME_END = 8'd85;
    localparam logic [7:0] PH_VTG_T    = 8'd110;
    localparam logic [7:0] PH_VTG_G    = 8'd111;
    localparam logic [7:0] PH_SKIP     = 8'd112;
    localparam logic [7:0] PH_COMMA    = 8'd140;
    localparam logic [7:0] PH_SPEED    = 8'd141;
    localparam logic [7:0] PH_DONE     = 8'd160;

    typedef enum logic [2:0] {
        TGT_NONE = 3'd0,
        TGT_LAT  = 3'd1,
        TGT_NS   = 3'd2,
        TGT_LON  = 3'd3,
        TGT_EW   = 3'd4,
        TGT_TIME = 3'd5,
        TGT_SPD  = 3'd6
    } t_target;

    typedef struct packed {
        logic       fix_valid;
        logic       speed_clear;
        logic [7:0] write_char;
        logic [4:0] write_index;
        t_target    write_target;
        logic [7:0] phase;
    } t_result;

endpackage

FILE: rtl/gvfe_in_stage.sv
// Input register of the field extractor: holds one received character and its
// valid flag. Depends on nothing but the flow signals from the top level.
`timescale 1ns / 1ps

module gvfe_in_stage (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_load,
    input  logic       i_drain,
    input  logic [7:0] i_char,
    output logic       o_valid,
    output logic [7:0] o_char
);

    logic       r_valid;
    logic       n_valid;
    logic [7:0] r_char;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_drain) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_char <= i_char;
        end
    end

    assign o_valid = r_valid;
    assign o_char  = r_char;

endmodule

FILE: rtl/gvfe_step.sv
// Transition logic of the field extractor: from the current phase, fix flag and
// one character it forms the result item and next state. Uses gvfe_pkg.
`timescale 1ns / 1ps

module gvfe_step #(
    parameter int COORD_CHARS = 20,
    parameter int TIME_CHARS  = 10,
    parameter int SPEED_CHARS = 8
) (
    input  logic              [7:0] i_phase,
    input  logic                    i_fix,
    input  logic              [7:0] i_char,
    output gvfe_pkg::t_result       o_result
);

    localparam logic [7:0] LAT_END   = 8'(20 + COORD_CHARS);
    localparam logic [7:0] LON_END   = 8'(50 + COORD_CHARS);
    localparam logic [7:0] TIME_END  = 8'(75 + TIME_CHARS);
    localparam logic [7:0] SPEED_END = 8'(141 + SPEED_CHARS);

    logic [7:0] w_nxt;
    logic       w_is_comma;

    assign w_nxt      = i_phase + 8'd1;
    assign w_is_comma = (i_char == gvfe_pkg::CH_COMMA);

    always_comb begin
        o_result              = '0;
        o_result.write_target = gvfe_pkg::TGT_NONE;
        o_result.phase        = i_phase;
        o_result.fix_valid    = i_fix;
        priority if (i_char == gvfe_pkg::CH_DOLLAR) begin
            o_result.phase = gvfe_pkg::PH_IDLE;
        end else if (i_phase == gvfe_pkg::PH_IDLE) begin
            o_result.phase = (i_char == gvfe_pkg::CH_G) ? gvfe_pkg::PH_HEAD_P : gvfe_pkg::PH_IDLE;
        end else if (i_phase == gvfe_pkg::PH_HEAD_P) begin
            o_result.phase = (i_char == gvfe_pkg::CH_P) ? gvfe_pkg::PH_HEAD_G : gvfe_pkg::PH_IDLE;
        end else if (i_phase == gvfe_pkg::PH_HEAD_G) begin
            priority if (i_char == gvfe_pkg::CH_G) begin
                o_result.phase = gvfe_pkg::PH_HEAD_L1;
            end else if (i_char == gvfe_pkg::CH_V) begin
                o_result.phase = gvfe_pkg::PH_VTG_T;
            end else begin
                o_result.phase = gvfe_pkg::PH_IDLE;
            end
        end else if (i_phase == gvfe_pkg::PH_HEAD_L1) begin
            o_result.phase = (i_char == gvfe_pkg::CH_L) ? gvfe_pkg::PH_HEAD_L2 : gvfe_pkg::PH_IDLE;
        end else if (i_phase == gvfe_pkg::PH_HEAD_L2) begin
            o_result.phase = (i_char == gvfe_pkg::CH_L) ? gvfe_pkg::PH_HEAD_CM : gvfe_pkg::PH_IDLE;
        end else if (i_phase == gvfe_pkg::PH_HEAD_CM) begin
            o_result.phase = w_is_comma ? gvfe_pkg::PH_LAT : gvfe_pkg::PH_IDLE;
        end else if (i_phase >= gvfe_pkg::PH_LAT && i_phase < LAT_END) begin
            if (w_is_comma) begin
                // An empty latitude field marks the fix invalid.
                if (i_phase == gvfe_pkg::PH_LAT) begin
                    o_result.fix_valid = 1'b0;
                end
                o_result.phase = gvfe_pkg::PH_NS;
            end else begin
                o_result.write_target = gvfe_pkg::TGT_LAT;
                o_result.write_index  = 5'(i_phase - gvfe_pkg::PH_LAT);
                o_result.write_char   = i_char;
                o_result.phase        = (w_nxt == LAT_END) ? gvfe_pkg::PH_NS : w_nxt;
            end
        end else if (i_phase >= gvfe_pkg::PH_NS && i_phase < gvfe_pkg::PH_NS_END) begin
            if (w_is_comma) begin
                o_result.phase = gvfe_pkg::PH_LON;
            end else begin
                o_result.write_target = gvfe_pkg::TGT_NS;
                o_result.write_char   = i_char;
                o_result.phase        = gvfe_pkg::PH_NS_SEEN;
            end
        end else if (i_phase >= gvfe_pkg::PH_LON && i_phase < LON_END) begin
            if (w_is_comma) begin
                if (i_phase == gvfe_pkg::PH_LON) begin
                    o_result.fix_valid = 1'b0;
                end
                o_result.phase = gvfe_pkg::PH_EW;
            end else begin
                o_result.write_target = gvfe_pkg::TGT_LON;
                o_result.write_index  = 5'(i_phase - gvfe_pkg::PH_LON);
                o_result.write_char   = i_char;
                o_result.phase        = (w_nxt == LON_END) ? gvfe_pkg::PH_EW : w_nxt;
            end
        end else if (i_phase >= gvfe_pkg::PH_EW && i_phase < gvfe_pkg::PH_TIME) begin
            if (w_is_comma) begin
                o_result.phase = gvfe_pkg::PH_TIME;
            end else begin
                // Any hemisphere letter marks the fix valid again.
                o_result.write_target = gvfe_pkg::TGT_EW;
                o_result.write_char   = i_char;
                o_result.fix_valid    = 1'b1;
                o_result.phase        = gvfe_pkg::PH_EW_SEEN;
            end
        end else if (i_phase >= gvfe_pkg::PH_TIME && i_phase < TIME_END) begin
            if (i_char == gvfe_pkg::CH_DOT) begin
                o_result.phase = gvfe_pkg::PH_TIME_END;
            end else begin
                if (i_fix) begin
                    o_result.write_target = gvfe_pkg::TGT_TIME;
                    o_result.write_index  = 5'(i_phase - gvfe_pkg::PH_TIME);
                    o_result.write_char   = i_char;
                end
                o_result.phase = (w_nxt == TIME_END) ? gvfe_pkg::PH_TIME_END : w_nxt;
            end
        end else if (i_phase == gvfe_pkg::PH_VTG_T) begin
            o_result.phase = (i_char == gvfe_pkg::CH_T) ? gvfe_pkg::PH_VTG_G : gvfe_pkg::PH_IDLE;
        end else if (i_phase == gvfe_pkg::PH_VTG_G) begin
            o_result.phase = (i_char == gvfe_pkg::CH_G) ? gvfe_pkg::PH_SKIP : gvfe_pkg::PH_IDLE;
        end else if (i_phase >= gvfe_pkg::PH_SKIP && i_phase < gvfe_pkg::PH_COMMA) begin
            // The skip count runs into the comma check even without an 'N'.
            o_result.phase = (i_char == gvfe_pkg::CH_N) ? gvfe_pkg::PH_COMMA : w_nxt;
        end else if (i_phase == gvfe_pkg::PH_COMMA) begin
            if (w_is_comma) begin
                o_result.speed_clear = 1'b1;
                o_result.phase       = gvfe_pkg::PH_SPEED;
            end else begin
                o_result.phase = gvfe_pkg::PH_IDLE;
            end
        end else if (i_phase >= gvfe_pkg::PH_SPEED && i_phase < SPEED_END) begin
            if (w_is_comma) begin
                o_result.phase = gvfe_pkg::PH_DONE;
            end else begin
                o_result.write_target = gvfe_pkg::TGT_SPD;
                o_result.write_index  = 5'(i_phase - gvfe_pkg::PH_SPEED);
                o_result.write_char   = i_char;
                o_result.phase        = w_nxt;
            end
        end else begin
            o_result.phase = i_phase;
        end
    end

endmodule

FILE: rtl/nmea_gll_vtg_field_extractor_unit.sv
// Top level of the NMEA GLL/VTG field extractor: input stage, transition
// logic, parse state and result register. Uses gvfe_pkg, gvfe_in_stage, gvfe_step.
`timescale 1ns / 1ps
//
// The block takes one received character per item on the slave stream and
// returns one result item per character on the master stream. The result
// carries the parse phase after the character, at most one character write
// (target field, index, character), the speed clear strobe and the fix flag.
// The field buffers themselves are kept by the receiver of the results.
//
// A character is first held in an input register, then the transition logic
// works on it together with the phase and fix flag, and the result register
// takes the outcome while the state updates in the same edge. A result item is
// therefore offered once its character has passed the input register and
// reached the result register. One item per cycle is sustained while
// i_m_tready stays high; the phase and flag loop closes inside one stage.
//
// Synchronous reset (i_rst_n low) clears both stage valid flags, the phase to
// zero and the fix flag to invalid. When the receiver holds i_m_tready low, the
// result stays in place, one more character is held in the input register, and
// then o_s_tready drops until the result is taken.
//
`include "assert_macros.svh"

module nmea_gll_vtg_field_extractor_unit #(
    parameter int COORD_CHARS = 20,
    parameter int TIME_CHARS  = 10,
    parameter int SPEED_CHARS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // Fields from bit 0: rx_char[7:0].
    input  logic [7:0]  i_s_tdata,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // Fields from bit 0: phase[7:0], write_target[10:8], write_index[15:11],
    // write_char[23:16], speed_clear[24], fix_valid[25], zeros[31:26].
    output logic [31:0] o_m_tdata
);

    logic              w_s1_valid;
    logic [7:0]        w_s1_char;
    logic              w_out_free;
    logic              w_s1_move;
    logic              w_accept;
    gvfe_pkg::t_result w_step;

    logic              r_out_valid;
    logic              n_out_valid;
    gvfe_pkg::t_result r_out;
    logic [7:0]        r_phase;
    logic              r_fix;

    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_s1_move  = w_s1_valid && w_out_free;
    assign o_s_tready = !w_s1_valid || w_out_free;
    assign w_accept   = i_s_tvalid && o_s_tready;

    gvfe_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_accept),
        .i_drain (w_s1_move),
        .i_char  (i_s_tdata),
        .o_valid (w_s1_valid),
        .o_char  (w_s1_char)
    );

    gvfe_step #(
        .COORD_CHARS (COORD_CHARS),
        .TIME_CHARS  (TIME_CHARS),
        .SPEED_CHARS (SPEED_CHARS)
    ) u_step (
        .i_phase  (r_phase),
        .i_fix    (r_fix),
        .i_char   (w_s1_char),
        .o_result (w_step)
    );

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_s1_move) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_phase     <= gvfe_pkg::PH_IDLE;
            r_fix       <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (w_s1_move) begin
                r_phase <= w_step.phase;
                r_fix   <= w_step.fix_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_move) begin
            r_out <= w_step;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {6'd0, r_out};

    // The parse state always matches the phase and flag of the last result.
    `ASSERT_IMPL(a_state_matches_out, i_clk, i_rst_n, r_out_valid,
        (r_phase == r_out.phase) && (r_fix == r_out.fix_valid),
        "parse state differs from the last result")
    // A result without a write carries zero index and character.
    `ASSERT_IMPL(a_no_write_zero, i_clk, i_rst_n,
        r_out_valid && (r_out.write_target == gvfe_pkg::TGT_NONE),
        (r_out.write_index == 5'd0) && (r_out.write_char == 8'd0),
        "write fields not zero without a write")
    // The speed clear strobe only comes with entry into speed capture.
    `ASSERT_IMPL(a_clear_phase, i_clk, i_rst_n, r_out_valid && r_out.speed_clear,
        (r_out.phase == gvfe_pkg::PH_SPEED) && (r_out.write_target == gvfe_pkg::TGT_NONE),
        "speed clear outside entry into speed capture")
    // A held character whose result cannot move stays held.
    `ASSERT_NEXT(a_s1_hold, i_clk, i_rst_n, w_s1_valid && !w_out_free,
        w_s1_valid && $stable(w_s1_char), "held character lost under stall")

endmodule
